[rtl/core/sdt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted defect table package
// Shared types, codes and sizes of the sorted defect table.
// ----------------------------------------------------------------------------
package sdt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   localparam logic [1:0] ACT_PHYS  = 2'd0;
   localparam logic [1:0] ACT_LOG   = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic [2:0] REG_BPS  = 3'd0;
   localparam logic [2:0] REG_SPT  = 3'd1;
   localparam logic [2:0] REG_SKEW = 3'd2;
   localparam logic [2:0] REG_CONV = 3'd3;
   localparam logic [2:0] REG_CLEN = 3'd4;

   localparam logic [23:0] OFFSET_MAX = 24'hFFFFFF;

   typedef struct packed {
      logic [15:0] cyl;
      logic [7:0]  head;
      logic        logical;
      logic [7:0]  sector;
      logic [23:0] offset;
      logic [15:0] length;
   } entry_type;

   typedef struct packed {
      logic load_new;
      logic shift_in;
   } cell_ctl_type;

endpackage
`default_nettype wire

[rtl/core/sdt_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted defect table channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] cylinder;
   logic [7:0]  head;
   logic [7:0]  sector;
   logic [23:0] bytes_from_index;
   logic [15:0] bit_length;
   logic [7:0]  entry_index;

   modport source (output valid, action, cylinder, head, sector, bytes_from_index,
                   bit_length, entry_index, input ready);
   modport sink (input valid, action, cylinder, head, sector, bytes_from_index,
                 bit_length, entry_index, output ready);
endinterface

interface sdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [8:0]  position;
   logic [8:0]  entry_count;
   logic [15:0] out_cylinder;
   logic [7:0]  out_head;
   logic        out_logical;
   logic [7:0]  out_sector;
   logic [23:0] out_offset;
   logic [15:0] out_length;

   modport source (output valid, status, position, entry_count, out_cylinder, out_head,
                   out_logical, out_sector, out_offset, out_length, input ready);
   modport sink (input valid, status, position, entry_count, out_cylinder, out_head,
                 out_logical, out_sector, out_offset, out_length, output ready);
endinterface
`default_nettype wire

[rtl/core/sdt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted defect table cell
// Holds one table entry, compares it against the new entry and takes either
// the new entry or its upper neighbor's entry.
// ----------------------------------------------------------------------------
module sdt_cell (
   input  wire                   clock,
   input  sdt_pkg::cell_ctl_type ctl,
   input  sdt_pkg::entry_type    new_entry,
   input  sdt_pkg::entry_type    prev_entry,
   output sdt_pkg::entry_type    entry,
   output logic                  brk,
   output logic                  match
);
   import sdt_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (ctl.load_new) begin
         entry_ff <= new_entry;
      end else if (ctl.shift_in) begin
         entry_ff <= prev_entry;
      end
   end

   assign entry = entry_ff;

   always_comb begin
      brk = entry_ff.logical || (new_entry.cyl < entry_ff.cyl) ||
            ((new_entry.cyl == entry_ff.cyl) &&
             ((new_entry.head < entry_ff.head) ||
              ((new_entry.head == entry_ff.head) && (new_entry.offset < entry_ff.offset))));
      match = !entry_ff.logical && (entry_ff.cyl == new_entry.cyl) &&
              (entry_ff.head == new_entry.head);
   end

endmodule
`default_nettype wire

[rtl/core/sdt_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted defect table remainder unit
// Restoring division, one quotient bit per cycle, giving the remainder.
// ----------------------------------------------------------------------------
module sdt_div (
   input  wire        clock,
   input  wire        reset,
   input  wire        start,
   input  wire  [8:0] dividend,
   input  wire  [8:0] divisor,
   output logic       done,
   output logic [7:0] remainder
);
   logic [8:0] rem_ff, rem_in;
   logic [8:0] num_ff, num_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       busy_ff, busy_in;
   logic       done_ff, done_in;
   logic [9:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[8]};
      if (start) begin
         rem_in  = 9'd0;
         num_in  = dividend;
         cnt_in  = 4'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_in = trial[8:0];
         num_in = {num_ff[7:0], 1'b0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd8) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[7:0];

endmodule
`default_nettype wire

[rtl/core/sorted_defect_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted defect table
// Defect table kept sorted by cylinder, head and offset in a chain of cells.
// ----------------------------------------------------------------------------
// Physical inserts, reads and clears go from the execute state to the response.
// A converted logical insert first waits on the remainder unit, then takes
// multiply, adjust, compare and execute steps before the response.
// One beat is in flight at a time; a new beat is taken the cycle after the
// response leaves.
// Synchronous reset empties the table and loads the register defaults.
module sorted_defect_table (
   input  wire              clock,
   input  wire              reset,
   sdt_req_if.sink          req_bus,
   sdt_rsp_if.source        rsp_bus,
   input  wire              csr_we,
   input  wire       [2:0]  csr_index,
   input  wire       [15:0] csr_wdata
);
   import sdt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_MUL, S_ADJ, S_CMP, S_EXEC, S_RESP
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   entry_type          new_ff, new_in;
   logic [7:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [15:0]        bps_ff, bps_in;
   logic [7:0]         spt_ff, spt_in;
   logic               skew_ff, skew_in;
   logic               conv_ff, conv_in;
   logic [15:0]        clen_ff, clen_in;
   logic [23:0]        off_ff, off_in;
   logic [23:0]        hb_ff, hb_in;
   logic signed [27:0] adj_ff, adj_in;
   logic [23:0]        poff_ff, poff_in;
   logic               found_ff, found_in;
   logic [1:0]         st_ff, st_in;
   logic [8:0]         pos_ff, pos_in;
   entry_type          out_ff, out_in;

   entry_type          cell_q [TABLE_DEPTH];
   cell_ctl_type       cell_ctl [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] brk, match, brk_eff, m_eff, in_use, load_vec;

   logic               ins_go, div_start, div_done;
   logic [8:0]         dividend, divisor;
   logic [7:0]         div_rem;
   logic [IDX_W-1:0]   ins_pos;
   logic [23:0]        first_off;
   entry_type          rd_entry;
   logic signed [27:0] up, ud;
   logic               le;
   logic [24:0]        sum;

   assign dividend = {1'b0, req_bus.sector} + (skew_ff ? {1'b0, req_bus.head} : 9'd0);
   assign divisor  = {1'b0, spt_ff} + 9'd1;
   assign div_start = (state_ff == S_IDLE) && req_bus.valid && (req_bus.action == ACT_LOG) &&
                      conv_ff && (int'(count_ff) < TABLE_DEPTH);

   sdt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign ins_go = (state_ff == S_EXEC) && ((op_ff == ACT_PHYS) || (op_ff == ACT_LOG)) &&
                   (int'(count_ff) < TABLE_DEPTH);

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         sdt_cell u_cell (
            .clock (clock), .ctl (cell_ctl[i]), .new_entry (new_ff),
            .prev_entry (new_ff), .entry (cell_q[i]), .brk (brk[i]), .match (match[i])
         );
      end else begin : g_body
         sdt_cell u_cell (
            .clock (clock), .ctl (cell_ctl[i]), .new_entry (new_ff),
            .prev_entry (cell_q[i-1]), .entry (cell_q[i]), .brk (brk[i]), .match (match[i])
         );
      end
   end

   always_comb begin
      ins_pos   = '0;
      first_off = '0;
      rd_entry  = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         in_use[i]  = i < int'(count_ff);
         brk_eff[i] = in_use[i] && brk[i] && !new_ff.logical;
         m_eff[i]   = in_use[i] && match[i];
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         logic prev_b;
         logic prev_m;
         prev_b = (i == 0) ? 1'b0 : brk_eff[(i == 0) ? 0 : i-1];
         prev_m = (i == 0) ? 1'b0 : m_eff[(i == 0) ? 0 : i-1];
         load_vec[i] = ins_go && !prev_b && (brk_eff[i] || (i == int'(count_ff)));
         cell_ctl[i].load_new = load_vec[i];
         cell_ctl[i].shift_in = ins_go && prev_b;
         if (load_vec[i]) begin
            ins_pos = ins_pos | IDX_W'(i);
         end
         if (m_eff[i] && !prev_m) begin
            first_off = first_off | cell_q[i].offset;
         end
         if (i == int'(idx_ff)) begin
            rd_entry = rd_entry | cell_q[i];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      new_in   = new_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      bps_in   = bps_ff;
      spt_in   = spt_ff;
      skew_in  = skew_ff;
      conv_in  = conv_ff;
      clen_in  = clen_ff;
      off_in   = off_ff;
      hb_in    = hb_ff;
      adj_in   = adj_ff;
      poff_in  = poff_ff;
      found_in = found_ff;
      st_in    = st_ff;
      pos_in   = pos_ff;
      out_in   = out_ff;
      up       = poff_ff < hb_ff ? (28'(poff_ff) + adj_ff) : 28'(poff_ff);
      ud       = off_ff < hb_ff ? (28'(off_ff) + adj_ff) : 28'(off_ff);
      le       = found_ff && (up <= ud);
      sum      = {1'b0, off_ff} + (le ? {9'd0, bps_ff} : 25'd0);

      if (csr_we) begin
         case (csr_index)
            REG_BPS:  bps_in  = csr_wdata;
            REG_SPT:  spt_in  = csr_wdata[7:0];
            REG_SKEW: skew_in = csr_wdata[0];
            REG_CONV: conv_in = csr_wdata[0];
            REG_CLEN: clen_in = csr_wdata;
            default:  ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in          = req_bus.action;
               idx_in         = req_bus.entry_index;
               new_in.cyl     = req_bus.cylinder;
               new_in.head    = req_bus.head;
               new_in.logical = (req_bus.action == ACT_LOG);
               new_in.sector  = (req_bus.action == ACT_LOG) ? req_bus.sector : 8'd0;
               new_in.offset  = (req_bus.action == ACT_PHYS) ? req_bus.bytes_from_index : 24'd0;
               new_in.length  = (req_bus.action == ACT_PHYS) ? req_bus.bit_length : 16'd0;
               state_in       = div_start ? S_DIV : S_EXEC;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            off_in   = 24'(bps_ff * div_rem);
            hb_in    = 24'(new_ff.head * bps_ff);
            poff_in  = first_off;
            found_in = |m_eff;
            state_in = S_ADJ;
         end
         S_ADJ: begin
            adj_in   = 28'(($signed({2'b0, divisor}) - $signed({3'b0, new_ff.head})) *
                           $signed({1'b0, bps_ff}));
            state_in = S_CMP;
         end
         S_CMP: begin
            new_in.logical = 1'b0;
            new_in.length  = clen_ff;
            new_in.offset  = sum[24] ? OFFSET_MAX : sum[23:0];
            state_in       = S_EXEC;
         end
         S_EXEC: begin
            st_in    = ST_OK;
            pos_in   = '0;
            out_in   = '0;
            state_in = S_RESP;
            case (op_ff)
               ACT_CLEAR: count_in = '0;
               ACT_READ: begin
                  if (int'(idx_ff) >= int'(count_ff)) begin
                     st_in = ST_RANGE;
                  end else begin
                     pos_in = {1'b0, idx_ff};
                     out_in = rd_entry;
                  end
               end
               default: begin
                  if (ins_go) begin
                     count_in = count_ff + CNT_W'(1);
                     pos_in   = 9'(ins_pos);
                     out_in   = new_ff;
                  end else begin
                     st_in = ST_FULL;
                  end
               end
            endcase
         end
         S_RESP: begin
            if (rsp_bus.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         bps_ff   <= 16'd512;
         spt_ff   <= 8'd32;
         skew_ff  <= 1'b0;
         conv_ff  <= 1'b0;
         clen_ff  <= 16'd512;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bps_ff   <= bps_in;
         spt_ff   <= spt_in;
         skew_ff  <= skew_in;
         conv_ff  <= conv_in;
         clen_ff  <= clen_in;
      end
      op_ff    <= op_in;
      new_ff   <= new_in;
      idx_ff   <= idx_in;
      off_ff   <= off_in;
      hb_ff    <= hb_in;
      adj_ff   <= adj_in;
      poff_ff  <= poff_in;
      found_ff <= found_in;
      st_ff    <= st_in;
      pos_ff   <= pos_in;
      out_ff   <= out_in;
   end

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign rsp_bus.valid        = (state_ff == S_RESP);
   assign rsp_bus.status       = st_ff;
   assign rsp_bus.position     = pos_ff;
   assign rsp_bus.entry_count  = 9'(count_ff);
   assign rsp_bus.out_cylinder = out_ff.cyl;
   assign rsp_bus.out_head     = out_ff.head;
   assign rsp_bus.out_logical  = out_ff.logical;
   assign rsp_bus.out_sector   = out_ff.sector;
   assign rsp_bus.out_offset   = out_ff.offset;
   assign rsp_bus.out_length   = out_ff.length;

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_bus.ready && rsp_bus.valid))
      else $error("request and response sides open at once");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= TABLE_DEPTH)
      else $error("entry count beyond table depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status == ST_FULL)) |-> (int'(count_ff) == TABLE_DEPTH))
      else $error("full status with room left");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      ins_go |-> $onehot(load_vec))
      else $error("insert does not load exactly one cell");

endmodule
`default_nettype wire
